// File: rtl/core/lpbck_pkg.sv
// Shared types, widths and register codes for the layer pixel blend unit.
package lpbck_pkg;

    localparam int MAX_DIM  = 4096;
    localparam int DIM_W    = 13;
    localparam int COORD_W  = 14;
    localparam int PIX_W    = 32;
    localparam int CHAN_W   = 8;
    localparam int KEY_W    = 24;
    localparam int MODE_W   = 2;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [MODE_W-1:0] MODE_RESET  = '0;
    localparam logic [CHAN_W-1:0] ALPHA_RESET = 8'hFF;
    localparam logic [KEY_W-1:0]  KEY_RESET   = '0;
    localparam logic [DIM_W-1:0]  CLIP_LO_RESET = '0;
    localparam logic [DIM_W-1:0]  CLIP_HI_RESET = DIM_W'(MAX_DIM);

    localparam int MODE_KEY_BIT   = 0;
    localparam int MODE_ALPHA_BIT = 1;

    typedef enum logic [2:0] {
        REG_LAYER_MODE  = 3'd0,
        REG_BLEND_ALPHA = 3'd1,
        REG_KEY_COLOR   = 3'd2,
        REG_CLIP_LEFT   = 3'd3,
        REG_CLIP_TOP    = 3'd4,
        REG_CLIP_RIGHT  = 3'd5,
        REG_CLIP_BOTTOM = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [MODE_W-1:0] layer_mode;
        logic [CHAN_W-1:0] blend_alpha;
        logic [KEY_W-1:0]  key_color;
        logic [DIM_W-1:0]  clip_left;
        logic [DIM_W-1:0]  clip_top;
        logic [DIM_W-1:0]  clip_right;
        logic [DIM_W-1:0]  clip_bottom;
    } cfg_t;

endpackage

// File: rtl/core/lpbck_if.sv
// Request channel interfaces for pixel input and blended result output.
interface lpbck_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [lpbck_pkg::COORD_W-1:0] dest_x;
    logic signed [lpbck_pkg::COORD_W-1:0] dest_y;
    logic [lpbck_pkg::PIX_W-1:0]        source_pixel;
    logic [lpbck_pkg::PIX_W-1:0]        dest_pixel;

    modport source (
        output valid, dest_x, dest_y, source_pixel, dest_pixel,
        input  ready
    );
    modport sink (
        input  valid, dest_x, dest_y, source_pixel, dest_pixel,
        output ready
    );
endinterface

interface lpbck_out_if;
    logic                        valid;
    logic                        ready;
    logic                        write_enable;
    logic [lpbck_pkg::PIX_W-1:0] result_pixel;

    modport source (
        output valid, write_enable, result_pixel,
        input  ready
    );
    modport sink (
        input  valid, write_enable, result_pixel,
        output ready
    );
endinterface

// File: rtl/core/lpbck_cfg_regs.sv
// APB configuration registers for the layer pixel blend unit.
module lpbck_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpbck_pkg::ADDR_W-1:0]  paddr,
    input  logic [lpbck_pkg::DATA_W-1:0]  pwdata,
    output logic [lpbck_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output lpbck_pkg::cfg_t               cfg
);
    import lpbck_pkg::*;

    logic [MODE_W-1:0] layer_mode_reg;
    logic [CHAN_W-1:0] blend_alpha_reg;
    logic [KEY_W-1:0]  key_color_reg;
    logic [DIM_W-1:0]  clip_left_reg;
    logic [DIM_W-1:0]  clip_top_reg;
    logic [DIM_W-1:0]  clip_right_reg;
    logic [DIM_W-1:0]  clip_bottom_reg;
    logic              wr_en;
    reg_idx_t          idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_mode_reg  <= MODE_RESET;
            blend_alpha_reg <= ALPHA_RESET;
            key_color_reg   <= KEY_RESET;
            clip_left_reg   <= CLIP_LO_RESET;
            clip_top_reg    <= CLIP_LO_RESET;
            clip_right_reg  <= CLIP_HI_RESET;
            clip_bottom_reg <= CLIP_HI_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_LAYER_MODE:  layer_mode_reg  <= pwdata[MODE_W-1:0];
                REG_BLEND_ALPHA: blend_alpha_reg <= pwdata[CHAN_W-1:0];
                REG_KEY_COLOR:   key_color_reg   <= pwdata[KEY_W-1:0];
                REG_CLIP_LEFT:   clip_left_reg   <= pwdata[DIM_W-1:0];
                REG_CLIP_TOP:    clip_top_reg    <= pwdata[DIM_W-1:0];
                REG_CLIP_RIGHT:  clip_right_reg  <= pwdata[DIM_W-1:0];
                REG_CLIP_BOTTOM: clip_bottom_reg <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_LAYER_MODE:  prdata = DATA_W'(layer_mode_reg);
            REG_BLEND_ALPHA: prdata = DATA_W'(blend_alpha_reg);
            REG_KEY_COLOR:   prdata = DATA_W'(key_color_reg);
            REG_CLIP_LEFT:   prdata = DATA_W'(clip_left_reg);
            REG_CLIP_TOP:    prdata = DATA_W'(clip_top_reg);
            REG_CLIP_RIGHT:  prdata = DATA_W'(clip_right_reg);
            REG_CLIP_BOTTOM: prdata = DATA_W'(clip_bottom_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.layer_mode  = layer_mode_reg;
    assign cfg.blend_alpha = blend_alpha_reg;
    assign cfg.key_color   = key_color_reg;
    assign cfg.clip_left   = clip_left_reg;
    assign cfg.clip_top    = clip_top_reg;
    assign cfg.clip_right  = clip_right_reg;
    assign cfg.clip_bottom = clip_bottom_reg;

endmodule

// File: rtl/core/lpbck_blend.sv
// Clip test, color key test and constant alpha mix for one pixel.
module lpbck_blend (
    input  lpbck_pkg::cfg_t                     cfg,
    input  logic signed [lpbck_pkg::COORD_W-1:0] dest_x,
    input  logic signed [lpbck_pkg::COORD_W-1:0] dest_y,
    input  logic [lpbck_pkg::PIX_W-1:0]         source_pixel,
    input  logic [lpbck_pkg::PIX_W-1:0]         dest_pixel,
    output logic                                write_enable,
    output logic [lpbck_pkg::PIX_W-1:0]         result_pixel
);
    import lpbck_pkg::*;

    localparam int CMP_W = COORD_W + 1;
    localparam int PROD_W = 2 * CHAN_W;

    function automatic logic signed [CMP_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] c;
        c = (32'(v) > MAX_DIM) ? DIM_W'(MAX_DIM) : v;
        return $signed(CMP_W'(c));
    endfunction

    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] v);
        logic [PROD_W:0] t;
        t = (PROD_W+1)'(v) + (PROD_W+1)'(v[PROD_W-1:CHAN_W]) + (PROD_W+1)'(1);
        return t[PROD_W-1:CHAN_W];
    endfunction

    logic signed [CMP_W-1:0] xs;
    logic signed [CMP_W-1:0] ys;
    logic                    in_clip;
    logic [KEY_W-1:0]        key_rgb;
    logic                    keyed;
    logic                    alpha_on;
    logic [CHAN_W-1:0]       inv_alpha;
    logic [PROD_W-1:0]       mix_sum [3];
    logic [PIX_W-1:0]        mixed;

    assign xs = CMP_W'(dest_x);
    assign ys = CMP_W'(dest_y);

    assign in_clip = (xs >= clamp_dim(cfg.clip_left)) && (xs < clamp_dim(cfg.clip_right))
                  && (ys >= clamp_dim(cfg.clip_top))  && (ys < clamp_dim(cfg.clip_bottom));

    assign key_rgb  = {cfg.key_color[7:0], cfg.key_color[15:8], cfg.key_color[23:16]};
    assign keyed    = cfg.layer_mode[MODE_KEY_BIT] && (source_pixel[KEY_W-1:0] == key_rgb);
    assign alpha_on = cfg.layer_mode[MODE_ALPHA_BIT] && (cfg.blend_alpha != 8'hFF);
    assign inv_alpha = ~cfg.blend_alpha;

    always_comb
    begin
        mixed = '0;
        for (int i = 0; i < 3; i++)
        begin
            mix_sum[i] = PROD_W'(source_pixel[i*CHAN_W +: CHAN_W]) * PROD_W'(cfg.blend_alpha)
                       + PROD_W'(dest_pixel[i*CHAN_W +: CHAN_W]) * PROD_W'(inv_alpha);
            mixed[i*CHAN_W +: CHAN_W] = div255(mix_sum[i]);
        end
    end

    always_comb
    begin
        write_enable = in_clip && !keyed;
        if (!write_enable)
            result_pixel = dest_pixel;
        else if (alpha_on)
            result_pixel = mixed;
        else
            result_pixel = source_pixel;
    end

endmodule

// File: rtl/core/layer_pixel_blend_with_color_key_unit.sv
// Top level of the layer pixel blend unit: input register, blend logic, result register.
// A taken request enters the input register, then the result register that drives the output.
// Throughput: one request per cycle unless the output stalls; each stage holds one request.
// Reset: rst_n clears both stage valid flags and loads the register defaults at once.
// Configuration writes apply to whatever request is in the input stage when the result is loaded.
module layer_pixel_blend_with_color_key_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpbck_pkg::ADDR_W-1:0]  paddr,
    input  logic [lpbck_pkg::DATA_W-1:0]  pwdata,
    output logic [lpbck_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    lpbck_in_if.sink                      pix_in,
    lpbck_out_if.source                   pix_out
);
    import lpbck_pkg::*;

    cfg_t                       cfg;
    logic                       in_valid_reg;
    logic signed [COORD_W-1:0]  x_reg;
    logic signed [COORD_W-1:0]  y_reg;
    logic [PIX_W-1:0]           spix_reg;
    logic [PIX_W-1:0]           dpix_reg;
    logic                       out_valid_reg;
    logic                       we_reg;
    logic [PIX_W-1:0]           res_reg;
    logic                       we_next;
    logic [PIX_W-1:0]           res_next;
    logic                       out_ready_int;
    logic                       in_take;
    logic                       out_load;

    lpbck_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lpbck_blend u_blend (
        .cfg          (cfg),
        .dest_x       (x_reg),
        .dest_y       (y_reg),
        .source_pixel (spix_reg),
        .dest_pixel   (dpix_reg),
        .write_enable (we_next),
        .result_pixel (res_next)
    );

    assign out_ready_int = !out_valid_reg || pix_out.ready;
    assign pix_in.ready  = !in_valid_reg || out_ready_int;
    assign in_take       = pix_in.valid && pix_in.ready;
    assign out_load      = in_valid_reg && out_ready_int;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pix_in.ready)
                in_valid_reg <= pix_in.valid;
            if (out_ready_int)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            x_reg    <= pix_in.dest_x;
            y_reg    <= pix_in.dest_y;
            spix_reg <= pix_in.source_pixel;
            dpix_reg <= pix_in.dest_pixel;
        end
        if (out_load)
        begin
            we_reg  <= we_next;
            res_reg <= res_next;
        end
    end

    assign pix_out.valid        = out_valid_reg;
    assign pix_out.write_enable = we_reg;
    assign pix_out.result_pixel = res_reg;

`ifndef SYNTHESIS
    a_take_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_valid_reg)
        else $error("accepted request missing from input stage");

    a_stage_moves_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("input stage request not moved to result stage");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_ready_int) |=> (in_valid_reg && $stable(spix_reg)))
        else $error("stalled input stage lost its request");

    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> pix_in.ready)
        else $error("empty input stage refused a request");
`endif

endmodule
